[rtl/averaged_light_duty_regulator_defines.svh]
// Assertion macros used by the regulator top level.
`ifndef AVERAGED_LIGHT_DUTY_REGULATOR_DEFINES_SVH
`define AVERAGED_LIGHT_DUTY_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define ALDR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define ALDR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/aldr_pkg.sv]
// Types and constants of the averaged light duty regulator.
package aldr_pkg;

  typedef struct packed {
    logic [15:0] light_sample;
    logic [7:0]  target_duty;
  } in_item_t;

  typedef enum logic [1:0] {
    REGION_UP   = 2'd0,
    REGION_DOWN = 2'd1,
    REGION_FINE = 2'd2
  } region_t;

  typedef struct packed {
    logic [7:0] duty;
    logic [7:0] scaled_light;
    region_t    region;
  } out_item_t;

  typedef struct packed {
    logic [7:0] coarse_band;
    logic [7:0] burst_limit;
    logic [7:0] fine_band;
  } cfg_t;

  localparam logic [1:0] CFG_COARSE_BAND = 2'd0;
  localparam logic [1:0] CFG_BURST_LIMIT = 2'd1;
  localparam logic [1:0] CFG_FINE_BAND   = 2'd2;

  localparam logic [7:0] COARSE_BAND_RST = 8'd80;
  localparam logic [7:0] BURST_LIMIT_RST = 8'd80;
  localparam logic [7:0] FINE_BAND_RST   = 8'd20;

endpackage

[rtl/averaged_light_duty_regulator.sv]
// Pipeline: four stages, the window sum, the product, the scaled light and the output register.
// Throughput: one beat per cycle while out_stall is low; each stage moves on as soon as the next one frees.
// The sample shift line, window sum, held duty and burst count clear at reset.
// Configuration resets to coarse band 80, burst limit 80 and fine band 20.
// Reset is synchronous and active low on rst_n.
`include "averaged_light_duty_regulator_defines.svh"

module averaged_light_duty_regulator #(
  parameter int WINDOW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aldr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aldr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_wdata
);
  import aldr_pkg::*;

  localparam int LOG_W  = $clog2(WINDOW);
  localparam int SUMW   = 16 + LOG_W;
  localparam int SHIFT  = SUMW + LOG_W;
  localparam int PRODW  = 2 * SUMW + 1;
  localparam longint unsigned RECIP_L = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;
  localparam logic [SUMW:0] RECIP = RECIP_L[SUMW:0];

  cfg_t            cfg_r;
  logic [15:0]     tap [WINDOW];
  logic [SUMW-1:0] sum_r;
  logic [7:0]      tgt1_r, tgt2_r, tgt3_r;
  logic [PRODW-1:0] prod_r;
  logic [7:0]      scaled_r;
  logic            v1_r, v2_r, v3_r, out_valid_r;
  out_item_t       out_data_r;
  out_item_t       result;
  logic            rdy_out, rdy3, rdy2, rdy1;
  logic            in_accept, ld2, ld3, ld_out;
  logic [15:0]     avg;
  logic [23:0]     avg_x255;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.coarse_band <= COARSE_BAND_RST;
      cfg_r.burst_limit <= BURST_LIMIT_RST;
      cfg_r.fine_band   <= FINE_BAND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COARSE_BAND: cfg_r.coarse_band <= cfg_wdata;
        CFG_BURST_LIMIT: cfg_r.burst_limit <= cfg_wdata;
        CFG_FINE_BAND:   cfg_r.fine_band   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Each stage advances when the stage after it is empty or moving.
  assign rdy_out   = !out_valid_r || !out_stall;
  assign rdy3      = !v3_r || rdy_out;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_stall  = !rdy1;
  assign in_accept = in_valid && rdy1;
  assign ld2       = v1_r && rdy2;
  assign ld3       = v2_r && rdy3;
  assign ld_out    = v3_r && rdy_out;

  // Shift line of samples; the last cell holds the oldest one in the window.
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      aldr_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (in_accept),
        .sample_in  (in_data.light_sample),
        .sample_out (tap[i])
      );
    end else begin : g_body
      aldr_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (in_accept),
        .sample_in  (tap[i-1]),
        .sample_out (tap[i])
      );
    end
  end

  // Stage 1: running window sum.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (in_accept) begin
      sum_r <= sum_r - SUMW'(tap[WINDOW-1]) + SUMW'(in_data.light_sample);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      tgt1_r <= in_data.target_duty;
    end
  end

  // Stage 2: divide by the window length through a rounded-up reciprocal.
  always_ff @(posedge clk) begin
    if (ld2) begin
      prod_r <= PRODW'(sum_r) * PRODW'(RECIP);
      tgt2_r <= tgt1_r;
    end
  end

  // Stage 3: scale the average by 255/65536.
  assign avg      = prod_r[SHIFT +: 16];
  assign avg_x255 = {avg, 8'd0} - {8'd0, avg};

  always_ff @(posedge clk) begin
    if (ld3) begin
      scaled_r <= avg_x255[23:16];
      tgt3_r   <= tgt2_r;
    end
  end

  // Stage 4: duty regulation into the output register.
  aldr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (ld_out),
    .cfg    (cfg_r),
    .target (tgt3_r),
    .scaled (scaled_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (ld_out) begin
      out_data_r <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1)    v1_r        <= in_valid;
      if (rdy2)    v2_r        <= v1_r;
      if (rdy3)    v3_r        <= v2_r;
      if (rdy_out) out_valid_r <= v3_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ALDR_ASSERT_NOW(a_stall_needs_busy, in_stall, v1_r && v2_r && v3_r && out_valid_r, "input stalled with a free stage")
  `ALDR_ASSERT_NEXT(a_load_gives_valid, ld_out, out_valid_r, "loaded beat not presented")
  `ALDR_ASSERT_NOW(a_scaled_range, out_valid_r, out_data_r.scaled_light != 8'd255, "scaled light out of range")
  `ALDR_ASSERT_NOW(a_region_code, out_valid_r, out_data_r.region != 2'd3, "bad region code")

endmodule

[rtl/aldr_cell.sv]
// One cell of the sample shift line: holds a sample and passes it on each beat.
module aldr_cell (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  logic [15:0] sample_in,
  output logic [15:0] sample_out
);

  logic [15:0] sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
    end else if (shift_en) begin
      sample_r <= sample_in;
    end
  end

  assign sample_out = sample_r;

endmodule

[rtl/aldr_ctrl.sv]
// Duty regulation stage: held duty, burst counter and region decision.
module aldr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  aldr_pkg::cfg_t     cfg,
  input  logic [7:0]         target,
  input  logic [7:0]         scaled,
  output aldr_pkg::out_item_t result
);
  import aldr_pkg::*;

  logic [7:0] held_r, held_nxt;
  logic [7:0] burst_r, burst_nxt;
  logic [7:0] duty_inc, duty_dec;
  logic       slew_up, slew_dn, fine_up, fine_dn;
  region_t    region;

  assign duty_inc = (held_r == 8'hFF) ? held_r : held_r + 8'd1;
  assign duty_dec = (held_r == 8'h00) ? held_r : held_r - 8'd1;

  // All compares are made one bit wider so the band additions never wrap.
  assign slew_up = ({1'b0, held_r} + {1'b0, cfg.coarse_band}) < {1'b0, target};
  assign slew_dn = {1'b0, held_r} > ({1'b0, target} + {1'b0, cfg.coarse_band});
  assign fine_dn = {1'b0, scaled} > ({1'b0, target} + {1'b0, cfg.fine_band});
  assign fine_up = ({1'b0, scaled} + {1'b0, cfg.fine_band}) < {1'b0, target};

  always_comb begin
    held_nxt  = held_r;
    burst_nxt = burst_r;
    region    = REGION_FINE;
    if (slew_up || slew_dn) begin
      region = slew_up ? REGION_UP : REGION_DOWN;
      // A burst of single steps ends with one idle beat that clears the count.
      if (burst_r < cfg.burst_limit) begin
        held_nxt  = slew_up ? duty_inc : duty_dec;
        burst_nxt = burst_r + 8'd1;
      end else begin
        burst_nxt = 8'd0;
      end
    end else if (fine_dn) begin
      held_nxt = duty_dec;
    end else if (fine_up) begin
      held_nxt = duty_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= 8'd0;
      burst_r <= 8'd0;
    end else if (load) begin
      held_r  <= held_nxt;
      burst_r <= burst_nxt;
    end
  end

  assign result.duty         = held_nxt;
  assign result.scaled_light = scaled;
  assign result.region       = region;

endmodule
